// File: sv/psta_pkg.sv
// ----------------------------------------------------------------------------
// psta_pkg: shared types and constants of the traffic anomaly detector
// Holds default sizes, configuration register indexes, reset values and the
// configuration record that travels from the register bank to the datapath.
// ----------------------------------------------------------------------------
package psta_pkg;

  // Default table sizes.
  localparam int unsigned DefSources    = 64;
  localparam int unsigned DefBurstDepth = 64;
  localparam int unsigned DefPortSlots  = 32;

  // Configuration register indexes.
  localparam logic [2:0] RegBurstWindow = 3'd0;
  localparam logic [2:0] RegBurstLimit  = 3'd1;
  localparam logic [2:0] RegScanWindow  = 3'd2;
  localparam logic [2:0] RegScanLimit   = 3'd3;
  localparam logic [2:0] RegFailWindow  = 3'd4;
  localparam logic [2:0] RegFailLimit   = 3'd5;
  localparam logic [2:0] RegSmallSize   = 3'd6;

  // Register reset values.
  localparam logic [15:0] RstBurstWindow = 16'd1;
  localparam logic [5:0]  RstBurstLimit  = 6'd50;
  localparam logic [15:0] RstScanWindow  = 16'd10;
  localparam logic [4:0]  RstScanLimit   = 5'd20;
  localparam logic [15:0] RstFailWindow  = 16'd30;
  localparam logic [15:0] RstFailLimit   = 16'd5;
  localparam logic [15:0] RstSmallSize   = 16'd100;

  // Failed attempt counter saturates here.
  localparam logic [15:0] FailCountMax = 16'hFFFF;

  typedef struct packed {
    logic [15:0] burst_window_s;
    logic [5:0]  burst_limit;
    logic [15:0] scan_window_s;
    logic [4:0]  scan_limit;
    logic [15:0] fail_window_s;
    logic [15:0] fail_limit;
    logic [15:0] small_size_limit;
  } cfg_t;

endpackage

// File: sv/psta_ram.sv
// ----------------------------------------------------------------------------
// psta_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module psta_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/psta_cfg.sv
// ----------------------------------------------------------------------------
// psta_cfg: configuration register bank
// Takes register writes from the configuration channel and holds the limits.
// ----------------------------------------------------------------------------
module psta_cfg
  import psta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register index; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBurstWindow: cfg_d.burst_window_s   = cfg_data_i;
        RegBurstLimit:  cfg_d.burst_limit      = cfg_data_i[5:0];
        RegScanWindow:  cfg_d.scan_window_s    = cfg_data_i;
        RegScanLimit:   cfg_d.scan_limit       = cfg_data_i[4:0];
        RegFailWindow:  cfg_d.fail_window_s    = cfg_data_i;
        RegFailLimit:   cfg_d.fail_limit       = cfg_data_i;
        RegSmallSize:   cfg_d.small_size_limit = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.burst_window_s   <= RstBurstWindow;
      cfg_q.burst_limit      <= RstBurstLimit;
      cfg_q.scan_window_s    <= RstScanWindow;
      cfg_q.scan_limit       <= RstScanLimit;
      cfg_q.fail_window_s    <= RstFailWindow;
      cfg_q.fail_limit       <= RstFailLimit;
      cfg_q.small_size_limit <= RstSmallSize;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: sv/per_source_traffic_anomaly_detector.sv
// ----------------------------------------------------------------------------
// per_source_traffic_anomaly_detector: per-source burst, scan and fail check
// Looks up each packet's source in a key table, then updates its ring of
// recent times and, for TCP, its destination port set and its failed attempt
// count, all held in synchronous RAMs, and reports one set of flags per packet.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: source_addr, dest_port, packet_len, now_s;
//                        tuser: is_tcp
//   m_axis    out        tdata: any_anomaly, burst_found, scan_found,
//                        failed_found, table_full
//   cfg       in         index 0..6, 16-bit data
//
// One packet holds the block while it steps through the stored keys, the
// expired ring times and the port slots, one read and one compare at a time;
// the single read port of each RAM sets this pace.
// Entries are allocated in order, so a fill count stands for the valid bits
// and no clearing pass follows reset. One packet is in work at a time; a
// finished result waits in the output register while the next is taken, and
// the last step waits while an earlier result is still held there.
// ----------------------------------------------------------------------------
module per_source_traffic_anomaly_detector
  import psta_pkg::*;
#(
  parameter int unsigned SOURCES     = DefSources,
  parameter int unsigned BURST_DEPTH = DefBurstDepth,
  parameter int unsigned PORT_SLOTS  = DefPortSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] source_addr, [47:32] dest_port, [63:48] packet_len, [95:64] now_s
  input  logic [95:0] s_axis_tdata_i,
  // [0] is_tcp
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] any_anomaly, [1] burst_found, [2] scan_found, [3] failed_found,
  // [4] table_full, [7:5] zero
  output logic [7:0]  m_axis_tdata_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IW  = SOURCES > 1 ? $clog2(SOURCES) : 1;
  localparam int unsigned CW  = $clog2(SOURCES + 1);
  localparam int unsigned BHW = $clog2(BURST_DEPTH);
  localparam int unsigned BFW = $clog2(BURST_DEPTH + 1);
  localparam int unsigned PIW = $clog2(PORT_SLOTS);
  localparam int unsigned PFW = $clog2(PORT_SLOTS + 1);
  localparam int unsigned BDEPTH = SOURCES * BURST_DEPTH;
  localparam int unsigned PDEPTH = SOURCES * PORT_SLOTS;
  localparam int unsigned BAW = $clog2(BDEPTH);
  localparam int unsigned PAW = $clog2(PDEPTH);
  localparam int unsigned RW  = BHW + BFW + PFW + 80;
  localparam int unsigned OffPf = 80;
  localparam int unsigned OffBf = 80 + PFW;
  localparam int unsigned OffBh = 80 + PFW + BFW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StKRd   = 4'd1;
  localparam logic [3:0] StKCmp  = 4'd2;
  localparam logic [3:0] StMiss  = 4'd3;
  localparam logic [3:0] StRRd   = 4'd4;
  localparam logic [3:0] StRLd   = 4'd5;
  localparam logic [3:0] StBPush = 4'd6;
  localparam logic [3:0] StBRd   = 4'd7;
  localparam logic [3:0] StBCmp  = 4'd8;
  localparam logic [3:0] StBDone = 4'd9;
  localparam logic [3:0] StScan  = 4'd10;
  localparam logic [3:0] StPRd   = 4'd11;
  localparam logic [3:0] StPCmp  = 4'd12;
  localparam logic [3:0] StPAdd  = 4'd13;
  localparam logic [3:0] StWb    = 4'd14;
  localparam logic [3:0] StFin   = 4'd15;

  cfg_t cfg;

  psta_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Control registers.
  logic [3:0]     state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic [IW-1:0]  entry_q, entry_d;
  logic           new_q, new_d;
  logic           out_valid_q, out_valid_d;
  logic [4:0]     out_q, out_d;
  // Request payload and per-entry working registers.
  logic [31:0]    src_q, src_d, now_q, now_d;
  logic [15:0]    port_q, port_d, len_q, len_d;
  logic           tcp_q, tcp_d;
  logic [BHW-1:0] bhead_q, bhead_d;
  logic [BFW-1:0] bfill_q, bfill_d;
  logic [PFW-1:0] pfill_q, pfill_d;
  logic [PIW-1:0] pidx_q, pidx_d;
  logic           seen_q, seen_d;
  logic [31:0]    sstart_q, sstart_d, fstart_q, fstart_d;
  logic [15:0]    fcnt_q, fcnt_d;
  logic           burst_q, burst_d, scan_q, scan_d, fail_q, fail_d, full_q, full_d;

  // RAM ports.
  logic           key_we, rec_we, bt_we, ps_we;
  logic [31:0]    key_rdata, bt_rdata;
  logic [15:0]    ps_rdata;
  logic [RW-1:0]  rec_rdata, rec_wdata;
  logic [BAW-1:0] bt_base, bt_waddr, bt_raddr;
  logic [PAW-1:0] ps_base, ps_waddr, ps_raddr;

  logic           in_acc;
  logic [BHW+1:0] push_sum;
  logic [BHW-1:0] push_pos, head_inc;
  logic [31:0]    fs_tmp;
  logic [15:0]    fc_tmp;
  logic [PFW-1:0] pf_tmp;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q};

  assign bt_base  = BAW'(entry_q) * BAW'(BURST_DEPTH);
  assign ps_base  = PAW'(entry_q) * PAW'(PORT_SLOTS);
  assign bt_raddr = bt_base + BAW'(bhead_q);
  assign ps_raddr = ps_base + PAW'(pidx_q);
  assign bt_we    = (state_q == StBPush);
  assign ps_we    = (state_q == StPAdd) && !seen_q && (pfill_q < PFW'(PORT_SLOTS));
  assign ps_waddr = ps_base + PAW'(pfill_q[PIW-1:0]);
  assign key_we   = (state_q == StWb) && new_q;
  assign rec_we   = (state_q == StWb);
  assign rec_wdata = {bhead_q, bfill_q, pfill_q, sstart_q, fcnt_q, fstart_q};

  // Ring position arithmetic, modulo the ring depth.
  assign push_sum = (BHW+2)'(bhead_q) + (BHW+2)'(bfill_q);
  assign push_pos = (push_sum >= (BHW+2)'(BURST_DEPTH)) ?
                    BHW'(push_sum - (BHW+2)'(BURST_DEPTH)) : BHW'(push_sum);
  assign head_inc = (bhead_q == BHW'(BURST_DEPTH - 1)) ? '0 : bhead_q + 1'b1;
  assign bt_waddr = bt_base + BAW'((bfill_q == BFW'(BURST_DEPTH)) ? bhead_q : push_pos);

  psta_ram #(.Width(32), .Depth(SOURCES)) u_key_ram (
    .clk_i (clk_i), .we_i (key_we), .waddr_i (entry_q), .wdata_i (src_q),
    .raddr_i (idx_q), .rdata_o (key_rdata)
  );

  psta_ram #(.Width(RW), .Depth(SOURCES)) u_rec_ram (
    .clk_i (clk_i), .we_i (rec_we), .waddr_i (entry_q), .wdata_i (rec_wdata),
    .raddr_i (entry_q), .rdata_o (rec_rdata)
  );

  psta_ram #(.Width(32), .Depth(BDEPTH)) u_time_ram (
    .clk_i (clk_i), .we_i (bt_we), .waddr_i (bt_waddr), .wdata_i (now_q),
    .raddr_i (bt_raddr), .rdata_o (bt_rdata)
  );

  psta_ram #(.Width(16), .Depth(PDEPTH)) u_port_ram (
    .clk_i (clk_i), .we_i (ps_we), .waddr_i (ps_waddr), .wdata_i (port_q),
    .raddr_i (ps_raddr), .rdata_o (ps_rdata)
  );

  // Sequencer: search, ring update, port set walk, counter update, write-back.
  always_comb begin
    fs_tmp      = fstart_q;
    fc_tmp      = fcnt_q;
    pf_tmp      = pfill_q;
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    entry_d     = entry_q;
    new_d       = new_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    src_d       = src_q;
    now_d       = now_q;
    port_d      = port_q;
    len_d       = len_q;
    tcp_d       = tcp_q;
    bhead_d     = bhead_q;
    bfill_d     = bfill_q;
    pfill_d     = pfill_q;
    pidx_d      = pidx_q;
    seen_d      = seen_q;
    sstart_d    = sstart_q;
    fstart_d    = fstart_q;
    fcnt_d      = fcnt_q;
    burst_d     = burst_q;
    scan_d      = scan_q;
    fail_d      = fail_q;
    full_d      = full_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          src_d   = s_axis_tdata_i[31:0];
          port_d  = s_axis_tdata_i[47:32];
          len_d   = s_axis_tdata_i[63:48];
          now_d   = s_axis_tdata_i[95:64];
          tcp_d   = s_axis_tuser_i;
          idx_d   = '0;
          new_d   = 1'b0;
          burst_d = 1'b0;
          scan_d  = 1'b0;
          fail_d  = 1'b0;
          full_d  = 1'b0;
          state_d = (count_q == '0) ? StMiss : StKRd;
        end
      end
      StKRd: state_d = StKCmp;
      StKCmp: begin
        if (key_rdata == src_q) begin
          entry_d = idx_q;
          state_d = StRRd;
        end else if (CW'(idx_q) + 1'b1 < count_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = StKRd;
        end else begin
          state_d = StMiss;
        end
      end
      StMiss: begin
        if (count_q == CW'(SOURCES)) begin
          full_d  = 1'b1;
          state_d = StFin;
        end else begin
          entry_d  = IW'(count_q);
          new_d    = 1'b1;
          bhead_d  = '0;
          bfill_d  = '0;
          pfill_d  = '0;
          sstart_d = '0;
          fcnt_d   = '0;
          fstart_d = '0;
          state_d  = StBPush;
        end
      end
      StRRd: state_d = StRLd;
      StRLd: begin
        fstart_d = rec_rdata[31:0];
        fcnt_d   = rec_rdata[47:32];
        sstart_d = rec_rdata[79:48];
        pfill_d  = rec_rdata[OffPf +: PFW];
        bfill_d  = rec_rdata[OffBf +: BFW];
        bhead_d  = rec_rdata[OffBh +: BHW];
        state_d  = StBPush;
      end
      StBPush: begin
        // A full ring overwrites its oldest time.
        if (bfill_q == BFW'(BURST_DEPTH)) begin
          bhead_d = head_inc;
        end else begin
          bfill_d = bfill_q + 1'b1;
        end
        state_d = StBRd;
      end
      StBRd: state_d = StBCmp;
      StBCmp: begin
        if ((now_q - bt_rdata) > {16'd0, cfg.burst_window_s}) begin
          bhead_d = head_inc;
          bfill_d = bfill_q - 1'b1;
          state_d = (bfill_q == BFW'(1)) ? StBDone : StBRd;
        end else begin
          state_d = StBDone;
        end
      end
      StBDone: begin
        burst_d = (32'(bfill_q) > 32'(cfg.burst_limit));
        state_d = tcp_q ? StScan : StWb;
      end
      StScan: begin
        // Restart the port set once its window has run out.
        if (pfill_q == '0) begin
          sstart_d = now_q;
        end else if ((now_q - sstart_q) > {16'd0, cfg.scan_window_s}) begin
          pf_tmp   = '0;
          sstart_d = now_q;
        end
        pfill_d = pf_tmp;
        pidx_d  = '0;
        seen_d  = 1'b0;
        state_d = (pf_tmp == '0) ? StPAdd : StPRd;
      end
      StPRd: state_d = StPCmp;
      StPCmp: begin
        if (ps_rdata == port_q) begin
          seen_d  = 1'b1;
          state_d = StPAdd;
        end else if (PFW'(pidx_q) + 1'b1 == pfill_q) begin
          state_d = StPAdd;
        end else begin
          pidx_d  = pidx_q + 1'b1;
          state_d = StPRd;
        end
      end
      StPAdd: begin
        if (!seen_q && (pfill_q < PFW'(PORT_SLOTS))) begin
          pf_tmp = pfill_q + 1'b1;
        end
        pfill_d = pf_tmp;
        scan_d  = (32'(pf_tmp) > 32'(cfg.scan_limit));
        // Small TCP packets count as failed attempts.
        if (len_q < cfg.small_size_limit) begin
          if (fcnt_q == '0) begin
            fs_tmp = now_q;
          end else if ((now_q - fstart_q) > {16'd0, cfg.fail_window_s}) begin
            fc_tmp = '0;
            fs_tmp = now_q;
          end
          if (fc_tmp != FailCountMax) begin
            fc_tmp = fc_tmp + 1'b1;
          end
          fcnt_d   = fc_tmp;
          fstart_d = fs_tmp;
          fail_d   = (fc_tmp > cfg.fail_limit);
        end
        state_d = StWb;
      end
      StWb: begin
        if (new_q) begin
          count_d = count_q + 1'b1;
        end
        state_d = StFin;
      end
      StFin: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_d = {full_q, fail_q, scan_q, burst_q, burst_q | scan_q | fail_q};
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    entry_q  <= entry_d;
    new_q    <= new_d;
    out_q    <= out_d;
    src_q    <= src_d;
    now_q    <= now_d;
    port_q   <= port_d;
    len_q    <= len_d;
    tcp_q    <= tcp_d;
    bhead_q  <= bhead_d;
    bfill_q  <= bfill_d;
    pfill_q  <= pfill_d;
    pidx_q   <= pidx_d;
    seen_q   <= seen_d;
    sstart_q <= sstart_d;
    fstart_q <= fstart_d;
    fcnt_q   <= fcnt_d;
    burst_q  <= burst_d;
    scan_q   <= scan_d;
    fail_q   <= fail_d;
    full_q   <= full_d;
  end

  // The allocation count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SOURCES))
    else $error("source count beyond table size");

  // Expiry compares only run on a non-empty ring.
  a_ring_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBCmp) |-> (bfill_q != '0))
    else $error("ring expiry on empty ring");

  // The port set never holds more than its slots.
  a_port_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPAdd) |-> (pfill_q <= PFW'(PORT_SLOTS)))
    else $error("port set overfilled");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != StIdle))
    else $error("request accepted without starting work");

endmodule
